// File: hdl/pfba_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command and status codes and state type for the
// page frame bitmap allocator. No dependencies.
package pfba_pkg;

	localparam int MAX_PAGES  = 65536;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_BITS  = 64;
	localparam int ADDR_W     = 48;
	localparam int CNT_W      = 17;
	localparam int PG_W       = 16;
	localparam int BIT_W      = 6;
	localparam int MAP_WORDS  = MAX_PAGES / WORD_BITS;
	localparam int MAP_AW     = 10;
	localparam int BND_W      = ADDR_W + 1 - PAGE_SHIFT;
	localparam int LOW_PAGES  = 256;
	localparam int IN_W       = 120;
	localparam int OUT_W      = 120;

	typedef enum logic [2:0] {
		CMD_BEGIN = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_END   = 3'd2,
		CMD_ALLOC = 3'd3,
		CMD_FREE  = 3'd4,
		CMD_ARUN  = 3'd5,
		CMD_FRUN  = 3'd6,
		CMD_BAD   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		STS_DONE    = 2'd0,
		STS_NOTRDY  = 2'd1,
		STS_INVALID = 2'd2,
		STS_NOFREE  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_FILL,
		ST_IDLE,
		ST_RNG_RD,
		ST_RNG_WR,
		ST_PG_RD,
		ST_PG_CHK,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_RUN_RD,
		ST_RUN_LD,
		ST_RUN_SCAN,
		ST_RESP
	} state_t;

	localparam logic [0:0] REG_KSTART = 1'b0;
	localparam logic [0:0] REG_KEND   = 1'b1;

endpackage

// File: hdl/page_frame_bitmap_allocator_top.sv
`timescale 1ns / 1ps
// Page frame bitmap allocator: used map in a 1024 x 64 synchronous memory,
// word-wise read-modify-write sequencer. Depends on pfba_pkg.
//
// channel | dir | handshake          | content
// s       | in  | s_tvalid/s_tready  | tuser: cmd, tdata: request fields
// m       | out | m_tvalid/m_tready  | tdata: result fields
// cfg     | in  | cfg_we             | kernel start / end address
//
// Range commands (add region, free run, run set) read then write each map word;
// page alloc reads then checks each word (up to 1025 words); run search reads,
// loads and then scans each word eight pages at a time; begin init and reset
// sweep the map once with s_tready low. Single free reads then writes one word.
// A finished result sits in the output register; the next beat is taken
// meanwhile, but a new result waits until m drains.
module page_frame_bitmap_allocator_top
	import pfba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [2:0]            s_tuser,  // cmd
	input  logic [IN_W-1:0]       s_tdata,  // address, region_length, region_usable, run_count
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // status, result_address, pages_changed,
	                                        // free_count, total_count, reserved_count, is_ready
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [ADDR_W-1:0]     cfg_data
);

	localparam logic [WORD_BITS-1:0] WORD_ONES = '1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAGES);

	function automatic logic [WORD_BITS-1:0] ge_mask(input logic [MAP_AW-1:0] w,
		input logic [BND_W-1:0] b);
		logic [BND_W-BIT_W-1:0] bw;
		begin
			bw = b[BND_W-1:BIT_W];
			if (bw < (BND_W-BIT_W)'(w))
				ge_mask = WORD_ONES;
			else if (bw == (BND_W-BIT_W)'(w))
				ge_mask = WORD_ONES << b[BIT_W-1:0];
			else
				ge_mask = '0;
		end
	endfunction

	function automatic logic [BIT_W:0] popcnt(input logic [WORD_BITS-1:0] v);
		logic [BIT_W:0] c;
		begin
			c = '0;
			for (int k = 0; k < WORD_BITS; k++)
				c = c + (BIT_W+1)'(v[k]);
			popcnt = c;
		end
	endfunction

	function automatic logic [BIT_W-1:0] lowest(input logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] idx;
		begin
			idx = '0;
			for (int k = WORD_BITS - 1; k >= 0; k--)
				if (v[k])
					idx = BIT_W'(k);
			lowest = idx;
		end
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] n);
		logic [CNT_W:0] s;
		begin
			s = {1'b0, a} + {1'b0, n};
			sat_add = (s > (CNT_W+1)'(MAX_PAGES)) ? MAX_CNT : s[CNT_W-1:0];
		end
	endfunction

	// map memory
	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 mem_we;
	logic [MAP_AW-1:0]    mem_wa;
	logic [WORD_BITS-1:0] mem_wd;

	state_t state_q, state_d, dec_next;

	logic [ADDR_W-PAGE_SHIFT-1:0] ksp_q;
	logic [BND_W-1:0]             kep_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [BND_W-1:0]             lo_q;
	logic [CNT_W-1:0]             hi_q;
	logic [MAP_AW-1:0]            w_q, wlast_q, fill_q;
	logic                         set_q, resv_q, resp_q;
	logic [CNT_W-1:0]             free_q, total_q, changed_q;
	logic [PG_W-1:0]              ss_q, pg_q, st_q;
	logic                         ready_q;
	status_t                      status_q;
	logic [ADDR_W-1:0]            res_q;
	logic [MAP_AW:0]              n_q;
	logic [CNT_W-1:0]             run_q;
	logic [2:0]                   c_q;
	logic [WORD_BITS-1:0]         word_q;

	logic                         out_valid_q;
	logic [OUT_W-1:0]             out_data_q;

	// request fields
	cmd_t                  in_cmd;
	logic [ADDR_W-1:0]     in_addr, in_len;
	logic                  in_usable;
	logic [CNT_W-1:0]      in_cnt;
	logic                  accept;

	assign in_cmd    = cmd_t'(s_tuser);
	assign in_addr   = s_tdata[47:0];
	assign in_len    = s_tdata[95:48];
	assign in_usable = s_tdata[96];
	assign in_cnt    = s_tdata[113:97];
	assign accept    = s_tvalid && s_tready;

	// decode
	logic [ADDR_W:0]              rg_lo_sum, rg_hi_sum;
	logic [BND_W-1:0]             rg_lo, rg_hi_raw, fr_lo, fr_hi_raw, d_lo;
	logic [CNT_W-1:0]             d_hi, d_hi_m1;
	logic [ADDR_W-PAGE_SHIFT-1:0] fp_pg;
	logic                         fp_bad;
	status_t                      d_status;

	always_comb begin
		rg_lo_sum = {1'b0, in_addr} + (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);
		rg_hi_sum = {1'b0, in_addr} + {1'b0, in_len};
		rg_lo     = rg_lo_sum[ADDR_W:PAGE_SHIFT];
		rg_hi_raw = rg_hi_sum[ADDR_W:PAGE_SHIFT];
		fr_lo     = {1'b0, in_addr[ADDR_W-1:PAGE_SHIFT]};
		fr_hi_raw = fr_lo + BND_W'(in_cnt);
		fp_pg     = in_addr[ADDR_W-1:PAGE_SHIFT];
		fp_bad    = (in_addr == '0) || (in_addr[PAGE_SHIFT-1:0] != '0)
			|| (fp_pg < (ADDR_W-PAGE_SHIFT)'(LOW_PAGES))
			|| ((fp_pg >= ksp_q) && ({1'b0, fp_pg} < kep_q))
			|| (in_addr[ADDR_W-1:PAGE_SHIFT+PG_W] != '0);
		d_lo      = rg_lo;
		d_hi      = (rg_hi_raw > BND_W'(MAX_PAGES)) ? MAX_CNT : rg_hi_raw[CNT_W-1:0];
		if (in_cmd == CMD_FRUN) begin
			d_lo = fr_lo;
			d_hi = (fr_hi_raw > BND_W'(MAX_PAGES)) ? MAX_CNT : fr_hi_raw[CNT_W-1:0];
		end
		d_hi_m1  = d_hi - CNT_W'(1);
		d_status = STS_DONE;
		dec_next = ST_RESP;
		unique case (in_cmd)
			CMD_BEGIN: dec_next = ST_FILL;
			CMD_ADD: begin
				if (in_usable && (in_len >= ADDR_W'(1 << PAGE_SHIFT))
					&& (d_lo < BND_W'(d_hi)))
					dec_next = ST_RNG_RD;
			end
			CMD_END: dec_next = ST_RESP;
			CMD_BAD: d_status = STS_INVALID;
			default: begin
				if (!ready_q)
					d_status = STS_NOTRDY;
				else if (in_cmd == CMD_ALLOC) begin
					if (free_q == '0)
						d_status = STS_NOFREE;
					else
						dec_next = ST_PG_RD;
				end else if (in_cmd == CMD_FREE) begin
					if (fp_bad)
						d_status = STS_INVALID;
					else
						dec_next = ST_FREE_RD;
				end else if (in_cmd == CMD_ARUN) begin
					if (in_cnt == '0)
						d_status = STS_INVALID;
					else if (free_q < in_cnt)
						d_status = STS_NOFREE;
					else
						dec_next = ST_RUN_RD;
				end else begin
					if ((in_addr == '0) || (in_cnt == '0))
						d_status = STS_INVALID;
					else if (d_lo < BND_W'(d_hi))
						dec_next = ST_RNG_RD;
				end
			end
		endcase
	end

	// range word update
	logic [WORD_BITS-1:0] rm, resv_m, am, used_m, rng_wd;
	logic [BIT_W:0]       pop_rm, pop_am, pop_used;

	always_comb begin
		rm     = ge_mask(w_q, lo_q) & ~ge_mask(w_q, BND_W'(hi_q));
		resv_m = ~ge_mask(w_q, BND_W'(LOW_PAGES))
			| (ge_mask(w_q, {1'b0, ksp_q}) & ~ge_mask(w_q, kep_q));
		am     = resv_q ? (rm & ~resv_m) : rm;
		used_m = rdata_q & am;
		rng_wd = set_q ? (rdata_q | am) : (rdata_q & ~am);
		pop_rm   = popcnt(rm);
		pop_am   = popcnt(am);
		pop_used = popcnt(used_m);
	end

	// single page search
	logic [WORD_BITS-1:0] pg_mask, pg_free;
	logic [BIT_W-1:0]     pg_bit;
	logic                 pg_hit, fr_hit;

	always_comb begin
		if (n_q == '0)
			pg_mask = ge_mask(w_q, BND_W'(ss_q));
		else if (n_q == (MAP_AW+1)'(MAP_WORDS))
			pg_mask = ~ge_mask(w_q, BND_W'(ss_q));
		else
			pg_mask = WORD_ONES;
		pg_free = ~rdata_q & pg_mask;
		pg_hit  = pg_free != '0;
		pg_bit  = lowest(pg_free);
		fr_hit  = rdata_q[pg_q[BIT_W-1:0]];
	end

	// run search, eight pages a cycle while scanning a loaded word
	logic [CNT_W-1:0] sc_run;
	logic [PG_W-1:0]  sc_st, sc_end, sc_p;
	logic             sc_hit;

	always_comb begin
		sc_run = run_q;
		sc_st  = st_q;
		sc_hit = 1'b0;
		sc_end = '0;
		for (int k = 0; k < 8; k++) begin
			sc_p = {w_q, c_q, 3'(k)};
			if (!sc_hit) begin
				if (!word_q[{c_q, 3'(k)}]) begin
					if (sc_run == '0)
						sc_st = sc_p;
					sc_run = sc_run + CNT_W'(1);
					if (sc_run == cnt_q) begin
						sc_hit = 1'b1;
						sc_end = sc_p;
					end
				end else begin
					sc_run = '0;
				end
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL:     if (fill_q == MAP_AW'(MAP_WORDS - 1))
				state_d = resp_q ? ST_RESP : ST_IDLE;
			ST_IDLE:     if (accept)
				state_d = dec_next;
			ST_RNG_RD:   state_d = ST_RNG_WR;
			ST_RNG_WR:   state_d = (w_q == wlast_q) ? ST_RESP : ST_RNG_RD;
			ST_PG_RD:    state_d = ST_PG_CHK;
			ST_PG_CHK:   state_d = (pg_hit || n_q == (MAP_AW+1)'(MAP_WORDS)) ?
				ST_RESP : ST_PG_RD;
			ST_FREE_RD:  state_d = ST_FREE_WR;
			ST_FREE_WR:  state_d = ST_RESP;
			ST_RUN_RD:   state_d = ST_RUN_LD;
			ST_RUN_LD:   state_d = ST_RUN_SCAN;
			ST_RUN_SCAN: begin
				if (sc_hit)
					state_d = ST_RNG_RD;
				else if (c_q == 3'd7)
					state_d = (w_q == MAP_AW'(MAP_WORDS - 1)) ? ST_RESP : ST_RUN_RD;
			end
			ST_RESP:     if (!out_valid_q || m_tready)
				state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = w_q;
		mem_wd   = rng_wd;
		unique case (state_q)
			ST_FILL: begin
				mem_we = 1'b1;
				mem_wa = fill_q;
				mem_wd = WORD_ONES;
			end
			ST_IDLE:    s_tready = 1'b1;
			ST_RNG_WR:  mem_we = 1'b1;
			ST_PG_CHK: begin
				mem_we = pg_hit;
				mem_wd = rdata_q | (WORD_BITS'(1) << pg_bit);
			end
			ST_FREE_WR: begin
				mem_we = fr_hit;
				mem_wd = rdata_q & ~(WORD_BITS'(1) << pg_q[BIT_W-1:0]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[w_q];
	end

	// configuration
	logic [ADDR_W:0] ke_sum;
	assign ke_sum = {1'b0, cfg_data} + (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksp_q <= '0;
			kep_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_KSTART)
				ksp_q <= cfg_data[ADDR_W-1:PAGE_SHIFT];
			else
				kep_q <= ke_sum[ADDR_W:PAGE_SHIFT];
		end
	end

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q  <= '0;
			resp_q  <= 1'b0;
			free_q  <= '0;
			total_q <= '0;
			ss_q    <= '0;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_FILL: fill_q <= fill_q + MAP_AW'(1);
				ST_IDLE: if (accept) begin
					if (in_cmd == CMD_BEGIN) begin
						fill_q  <= '0;
						resp_q  <= 1'b1;
						free_q  <= '0;
						total_q <= '0;
						ss_q    <= '0;
						ready_q <= 1'b0;
					end else if (in_cmd == CMD_END) begin
						ready_q <= free_q != '0;
					end
				end
				ST_RNG_WR: begin
					if (resv_q) begin
						total_q <= sat_add(total_q, CNT_W'(pop_rm));
						free_q  <= sat_add(free_q, CNT_W'(pop_am));
					end else if (!set_q) begin
						free_q  <= sat_add(free_q, CNT_W'(pop_used));
					end
				end
				ST_PG_CHK: if (pg_hit) begin
					free_q <= free_q - CNT_W'(1);
					ss_q   <= {w_q, pg_bit};
				end
				ST_FREE_WR: if (fr_hit) begin
					free_q <= sat_add(free_q, CNT_W'(1));
					if (pg_q < ss_q)
						ss_q <= pg_q;
				end
				ST_RUN_SCAN: if (sc_hit)
					free_q <= free_q - cnt_q;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (accept) begin
				status_q  <= d_status;
				changed_q <= '0;
				res_q     <= '0;
				cnt_q     <= in_cnt;
				lo_q      <= d_lo;
				hi_q      <= d_hi;
				w_q       <= d_lo[PG_W-1:BIT_W];
				wlast_q   <= d_hi_m1[PG_W-1:BIT_W];
				set_q     <= 1'b0;
				resv_q    <= in_cmd == CMD_ADD;
				pg_q      <= fp_pg[PG_W-1:0];
				n_q       <= '0;
				run_q     <= '0;
				st_q      <= '0;
				if (in_cmd == CMD_ALLOC)
					w_q <= ss_q[PG_W-1:BIT_W];
				else if (in_cmd == CMD_FREE)
					w_q <= fp_pg[PG_W-1:BIT_W];
				else if (in_cmd == CMD_ARUN)
					w_q <= '0;
				if (in_cmd == CMD_ALLOC || in_cmd == CMD_ARUN)
					status_q <= (d_status == STS_DONE) ? STS_NOFREE : d_status;
			end
			ST_RNG_WR: begin
				if (!set_q)
					changed_q <= changed_q + CNT_W'(pop_used);
				w_q <= w_q + MAP_AW'(1);
			end
			ST_PG_CHK: begin
				if (pg_hit) begin
					status_q  <= STS_DONE;
					changed_q <= CNT_W'(1);
					res_q     <= ADDR_W'({w_q, pg_bit}) << PAGE_SHIFT;
				end else begin
					n_q <= n_q + (MAP_AW+1)'(1);
					w_q <= w_q + MAP_AW'(1);
				end
			end
			ST_FREE_WR: if (fr_hit)
				changed_q <= CNT_W'(1);
			ST_RUN_LD: begin
				word_q <= rdata_q;
				c_q    <= '0;
			end
			ST_RUN_SCAN: begin
				run_q <= sc_run;
				st_q  <= sc_st;
				c_q   <= c_q + 3'd1;
				if (sc_hit) begin
					status_q  <= STS_DONE;
					changed_q <= cnt_q;
					res_q     <= ADDR_W'(sc_st) << PAGE_SHIFT;
					set_q     <= 1'b1;
					resv_q    <= 1'b0;
					lo_q      <= BND_W'(sc_st);
					hi_q      <= CNT_W'(sc_end) + CNT_W'(1);
					w_q       <= sc_st[PG_W-1:BIT_W];
					wlast_q   <= sc_end[PG_W-1:BIT_W];
				end else if (c_q == 3'd7 && w_q != MAP_AW'(MAP_WORDS - 1)) begin
					w_q <= w_q + MAP_AW'(1);
				end
			end
			default: ;
		endcase
	end

	// result register
	logic [CNT_W-1:0] rsv_cnt;
	assign rsv_cnt = (total_q > free_q) ? (total_q - free_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_RESP && (!out_valid_q || m_tready))
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && (!out_valid_q || m_tready))
			out_data_q <= {1'b0, ready_q, rsv_cnt, total_q, free_q, changed_q, res_q,
				status_q};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("map written while idle");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted beat produced no work");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q <= MAX_CNT) && (total_q <= MAX_CNT))
		else $error("counter above page count");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PG_CHK) |-> (n_q <= (MAP_AW+1)'(MAP_WORDS)))
		else $error("page search ran past wrap");

	a_resp_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && (!out_valid_q || m_tready)) |=> m_tvalid)
		else $error("result not presented");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for page_frame_bitmap_allocator_top: directed and random
// command streams, checked against a bit-level model of the page map.
// Depends on pfba_pkg and the allocator top level.
module tb;
	import pfba_pkg::*;

	localparam int LIMIT = 60000;

	typedef struct packed {
		status_t     status;
		logic [47:0] addr;
		logic [16:0] changed;
		logic [16:0] free_n;
		logic [16:0] total_n;
		logic [16:0] rsvd_n;
		logic        ready;
	} reply_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [2:0]        s_tuser = CMD_BEGIN;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_we = 1'b0;
	logic [0:0]        cfg_index = REG_KSTART;
	logic [ADDR_W-1:0] cfg_data = '0;

	// model state
	bit          frame_used [MAX_PAGES];
	int          search_idx;
	int          free_n;
	int          total_n;
	bit          ready_flag;
	logic [47:0] k_start;
	logic [47:0] k_end;

	reply_t      expected_replies [$];
	logic [47:0] held_pages [$];
	int          errors = 0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          idle_cycles = 0;
	bit          steady = 1'b0;
	bit          long_hold = 1'b0;

	page_frame_bitmap_allocator_top i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit page_reserved(longint unsigned pa);
		longint unsigned ks, ke;
		ks = k_start & ~64'hFFF;
		ke = (longint'(k_end) + 64'hFFF) & ~64'hFFF;
		if (pa < 64'h100000)
			return 1'b1;
		return !((pa + 4096 <= ks) || (ke <= pa));
	endfunction

	function automatic reply_t predict_frame_op(cmd_t c, logic [47:0] a, logic [47:0] len,
			logic u, logic [16:0] n);
		reply_t r;
		longint unsigned lo, hi, i, k, st, run;
		bit found;
		r = '0;
		r.status = STS_DONE;
		found = 0;
		if (c == CMD_BEGIN) begin
			foreach (frame_used[j]) frame_used[j] = 1'b1;
			search_idx = 0;
			free_n = 0;
			total_n = 0;
			ready_flag = 0;
		end else if (c == CMD_ADD) begin
			if (u && len >= 4096) begin
				lo = (longint'(a) + 4095) >> PAGE_SHIFT;
				hi = (longint'(a) + longint'(len)) >> PAGE_SHIFT;
				if (hi > MAX_PAGES)
					hi = MAX_PAGES;
				for (i = lo; i < hi; i++) begin
					if (total_n < MAX_PAGES) total_n++;
					if (!page_reserved(i << PAGE_SHIFT)) begin
						if (frame_used[i]) r.changed++;
						frame_used[i] = 1'b0;
						if (free_n < MAX_PAGES) free_n++;
					end
				end
			end
		end else if (c == CMD_END) begin
			ready_flag = free_n != 0;
		end else if (c == CMD_BAD) begin
			r.status = STS_INVALID;
		end else if (!ready_flag) begin
			r.status = STS_NOTRDY;
		end else if (c == CMD_ALLOC) begin
			r.status = STS_NOFREE;
			if (free_n != 0) begin
				for (k = 0; k < MAX_PAGES && !found; k++) begin
					i = (search_idx + k) % MAX_PAGES;
					if (!frame_used[i]) begin
						frame_used[i] = 1'b1;
						free_n--;
						search_idx = int'(i);
						r.addr = 48'(i << PAGE_SHIFT);
						r.changed = 1;
						r.status = STS_DONE;
						found = 1;
					end
				end
			end
		end else if (c == CMD_FREE) begin
			i = a >> PAGE_SHIFT;
			if (a == 0 || a[11:0] != 0 || page_reserved(a) || i >= MAX_PAGES) begin
				r.status = STS_INVALID;
			end else if (frame_used[i]) begin
				frame_used[i] = 1'b0;
				if (free_n < MAX_PAGES) free_n++;
				if (i < search_idx) search_idx = int'(i);
				r.changed = 1;
			end
		end else if (c == CMD_ARUN) begin
			if (n == 0) begin
				r.status = STS_INVALID;
			end else if (free_n < n) begin
				r.status = STS_NOFREE;
			end else begin
				r.status = STS_NOFREE;
				run = 0;
				st = 0;
				for (i = 0; i < MAX_PAGES; i++) begin
					if (!frame_used[i]) begin
						if (run == 0) st = i;
						run++;
						if (run == n) begin
							for (k = st; k <= i; k++) frame_used[k] = 1'b1;
							free_n -= n;
							r.addr = 48'(st << PAGE_SHIFT);
							r.changed = n;
							r.status = STS_DONE;
							break;
						end
					end else begin
						run = 0;
					end
				end
			end
		end else begin
			if (a == 0 || n == 0) begin
				r.status = STS_INVALID;
			end else begin
				lo = a >> PAGE_SHIFT;
				for (i = 0; i < n; i++) begin
					if (lo + i < MAX_PAGES && frame_used[lo + i]) begin
						frame_used[lo + i] = 1'b0;
						if (free_n < MAX_PAGES) free_n++;
						r.changed++;
					end
				end
			end
		end
		r.free_n = 17'(free_n);
		r.total_n = 17'(total_n);
		r.rsvd_n = total_n > free_n ? 17'(total_n - free_n) : 17'd0;
		r.ready = ready_flag;
		return r;
	endfunction

	task automatic send_req(cmd_t c, logic [47:0] a = 0, logic [47:0] len = 0,
			logic u = 0, logic [16:0] n = 0);
		int gap;
		reply_t r;
		gap = steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser <= c;
		s_tdata <= {6'b0, n, u, len, a};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		r = predict_frame_op(c, a, len, u, n);
		expected_replies.push_back(r);
		beats_in++;
		if (c == CMD_ALLOC && r.status == STS_DONE)
			held_pages.push_back(r.addr);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		wait (expected_replies.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [47:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KSTART) k_start = v; else k_end = v;
		@(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// response side: random stalls, one long hold-off on request
	initial begin
		int stall;
		reply_t got, want;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 11);
			if (long_hold) begin
				stall = 400;
				long_hold = 1'b0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			beats_out++;
			got = {status_t'(m_tdata[1:0]), m_tdata[49:2], m_tdata[66:50], m_tdata[83:67],
				m_tdata[100:84], m_tdata[117:101], m_tdata[118]};
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected beat %p", $time, got);
				errors++;
			end else begin
				want = expected_replies.pop_front();
				if (got.status != want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.addr != want.addr) begin
					$display("%0t: address exp %h got %h", $time, want.addr, got.addr);
					errors++;
				end
				if (got.changed != want.changed) begin
					$display("%0t: changed exp %0d got %0d", $time, want.changed, got.changed);
					errors++;
				end
				if (got.free_n != want.free_n) begin
					$display("%0t: free exp %0d got %0d", $time, want.free_n, got.free_n);
					errors++;
				end
				if (got.total_n != want.total_n) begin
					$display("%0t: total exp %0d got %0d", $time, want.total_n, got.total_n);
					errors++;
				end
				if (got.rsvd_n != want.rsvd_n) begin
					$display("%0t: reserved exp %0d got %0d", $time, want.rsvd_n, got.rsvd_n);
					errors++;
				end
				if (got.ready != want.ready) begin
					$display("%0t: ready exp %0d got %0d", $time, want.ready, got.ready);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic test_directed();
		write_reg(REG_KSTART, 48'h180000);
		write_reg(REG_KEND, 48'h1C0800);
		send_req(CMD_ALLOC);
		send_req(CMD_FRUN, 48'h200000, 0, 0, 4);
		send_req(CMD_BAD);
		send_req(CMD_BEGIN);
		send_req(CMD_ADD, 48'h100800, 48'h200000, 1);
		send_req(CMD_ADD, 48'h400000, 48'h10000, 0);
		send_req(CMD_ADD, 48'h500000, 48'hFFF, 1);
		send_req(CMD_ADD, 48'h0, 48'h80000, 1);
		send_req(CMD_ADD, 48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF, 1);
		send_req(CMD_END);
		send_req(CMD_ALLOC);
		send_req(CMD_FREE, 48'h101000);
		send_req(CMD_FREE, 48'h0);
		send_req(CMD_FREE, 48'h200010);
		send_req(CMD_FREE, 48'h180000);
		send_req(CMD_FREE, 48'h10000000);
		send_req(CMD_FREE, 48'h250000);
		send_req(CMD_ARUN, 0, 0, 0, 0);
		send_req(CMD_ARUN, 0, 0, 0, 17'h10000);
		send_req(CMD_ARUN, 0, 0, 0, 5);
		send_req(CMD_FRUN, 48'h0, 0, 0, 3);
		send_req(CMD_FRUN, 48'h101FFF, 0, 0, 0);
		send_req(CMD_FRUN, 48'h101FFF, 0, 0, 3);
		send_req(CMD_FRUN, 48'hFFF_F000, 0, 0, 17'h1FFFF);
		drain();
	endtask

	task automatic test_kernel_extremes();
		write_reg(REG_KSTART, 48'h0);
		write_reg(REG_KEND, 48'hFFFF_FFFF_FFFF);
		send_req(CMD_BEGIN);
		send_req(CMD_ADD, 48'h100000, 48'h100000, 1);
		send_req(CMD_END);
		send_req(CMD_ALLOC);
		send_req(CMD_FREE, 48'h180000);
		drain();
	endtask

	task automatic run_phase(int ops, bit full_map);
		int pick, nreg;
		logic [47:0] a;
		held_pages.delete();
		send_req(CMD_BEGIN);
		if (full_map) begin
			send_req(CMD_ADD, 48'h0, 48'hFFFF_FFFF_FFFF, 1);
		end else begin
			nreg = $urandom_range(1, 4);
			repeat (nreg)
				send_req(CMD_ADD, 48'h100000 + 48'($urandom_range(0, 32'h2000000)),
					48'($urandom_range(4096, 32'h400000)), $urandom_range(0, 7) != 0);
		end
		send_req(CMD_END);
		repeat (ops) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_req(CMD_ALLOC);
			end else if (pick < 75 && held_pages.size() > 0) begin
				a = held_pages[$urandom_range(0, held_pages.size() - 1)];
				send_req(CMD_FREE, a);
			end else if (pick < 80) begin
				send_req(CMD_ARUN, 0, 0, 0, 17'($urandom_range(1, 16)));
			end else if (pick < 81) begin
				send_req(CMD_ARUN, 0, 0, 0, 17'($urandom_range(1, 32'h10000)));
			end else if (pick < 86) begin
				send_req(CMD_FRUN, 48'h100000 + 48'($urandom_range(0, 32'h2000000)), 0, 0,
					17'($urandom_range(1, 64)));
			end else if (pick < 88) begin
				send_req(CMD_ADD, 48'h100000 + 48'($urandom_range(0, 32'h800000)),
					48'($urandom_range(0, 32'h40000)), 1'($urandom_range(0, 1)));
			end else if (pick < 94) begin
				send_req(CMD_FREE, 48'({$urandom_range(0, 32'h3000), 12'h0} ^
					($urandom_range(0, 3) == 0 ? $urandom_range(1, 4095) : 0)));
			end else begin
				send_req(cmd_t'($urandom_range(3, 7)), rand48(), rand48(),
					1'($urandom_range(0, 1)), 17'($urandom_range(0, 32'h1FFFF)));
			end
		end
		drain();
	endtask

	task automatic test_random();
		for (int p = 0; p < 9; p++) begin
			steady = (p % 3 == 1);
			case (p)
			0: begin
				write_reg(REG_KSTART, 48'h0);
				write_reg(REG_KEND, 48'h0);
			end
			1: begin
				write_reg(REG_KSTART, 48'hFFFF_FFFF_FFFF);
				write_reg(REG_KEND, 48'hFFFF_FFFF_FFFF);
			end
			2: begin
				write_reg(REG_KSTART, 48'h800000);
				write_reg(REG_KEND, 48'h400000);
			end
			default: begin
				write_reg(REG_KSTART, 48'h100000 + 48'($urandom_range(0, 32'h1000000)));
				write_reg(REG_KEND, k_start + 48'($urandom_range(0, 32'h400000)));
			end
			endcase
			if (p == 4)
				long_hold = 1'b1;
			run_phase(186, p == 5);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (frame_used[j]) frame_used[j] = 1'b1;
		search_idx = 0;
		free_n = 0;
		total_n = 0;
		ready_flag = 0;
		k_start = 0;
		k_end = 0;
		@(posedge clk);
		test_directed();
		test_kernel_extremes();
		test_random();
		wait (expected_replies.size() == 0);
		repeat (50) @(posedge clk);
		$display("covered %0d requests and %0d replies over directed, kernel-extreme", beats_in,
			beats_out);
		$display("and nine random allocate/free phases with one long reply stall");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
